FILE: sv/worker_pool_task_dispatcher_unit_assert.svh
// Assertion macros shared by the dispatcher.
`ifndef WORKER_POOL_TASK_DISPATCHER_UNIT_ASSERT_SVH
`define WORKER_POOL_TASK_DISPATCHER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WPTD_ASSERT_NOW(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("dispatcher assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WPTD_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("dispatcher assertion failed");

`endif

FILE: sv/wptd_pkg.sv
`default_nettype none
package wptd_pkg;

  localparam int WORKERS     = 8;
  localparam int WID_W       = 3;
  localparam int LINK_W      = 4;
  localparam logic [LINK_W-1:0] NIL = 4'd8;
  localparam int CNT_W       = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = 4;
  localparam int QCNT_W      = 5;
  localparam int TASK_BITS   = 32;
  localparam int TIME_W      = 32;
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 3;
  localparam int CMD_W       = 2;

  localparam logic [CMD_W-1:0] CMD_SUBMIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FINISH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

  localparam logic [KIND_W-1:0] KIND_TO_IDLE  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TO_NEW   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FROM_Q   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_PARKED   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RELEASED = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RETIRED  = 3'd7;

  localparam logic [MODE_W-1:0] MODE_EXIT = 2'd0;

  localparam logic REG_IDLE_MODE    = 1'b0;
  localparam logic REG_IDLE_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [TASK_BITS-1:0] task_id;
    logic [WID_W-1:0]     worker_id;
    logic [TIME_W-1:0]    now;
  } task_word_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [WID_W-1:0]     worker_out;
    logic [TASK_BITS-1:0] task_out;
    logic [CNT_W-1:0]     active_count;
    logic [QCNT_W-1:0]    queued_count;
    logic                 last;
  } result_word_t;

  typedef enum logic [1:0] {
    OP_SUBMIT,
    OP_FINISH,
    OP_TICK
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [TASK_BITS-1:0] task_id;
    logic [WID_W-1:0]     worker_id;
    logic [TIME_W-1:0]    now;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } front_if_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [TIME_W-1:0] timeout;
  } cfg_t;

  typedef enum logic {
    ST_RUN,
    ST_RETIRE
  } back_state_t;

endpackage
`default_nettype wire

FILE: sv/wptd_front.sv
`default_nettype none
module wptd_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire wptd_pkg::task_word_t task_in,
  output logic                      full,
  input  wire logic                 take,
  output wptd_pkg::front_if_t       front
);

  // Two-entry queue of classified words; unknown commands are dropped here.
  wptd_pkg::item_t q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       accept;
  logic       keep;
  wptd_pkg::item_t cls;

  always_comb begin
    cls.task_id   = task_in.task_id;
    cls.worker_id = task_in.worker_id;
    cls.now       = task_in.now;
    keep          = 1'b1;
    case (task_in.command)
      wptd_pkg::CMD_SUBMIT: cls.op = wptd_pkg::OP_SUBMIT;
      wptd_pkg::CMD_FINISH: cls.op = wptd_pkg::OP_FINISH;
      wptd_pkg::CMD_TICK:   cls.op = wptd_pkg::OP_TICK;
      default: begin
        cls.op = wptd_pkg::OP_TICK;
        keep   = 1'b0;
      end
    endcase
  end

  assign full   = (count == 2'd2);
  assign accept = push && !full && keep;
  assign front.valid = (count != 2'd0);
  assign front.item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept) wr_ptr <= ~wr_ptr;
      if (take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, accept} - {1'b0, take};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) q_mem[wr_ptr] <= cls;
  end

endmodule
`default_nettype wire

FILE: sv/wptd_back.sv
`default_nettype none
module wptd_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire wptd_pkg::front_if_t front,
  output logic                     take,
  input  wire wptd_pkg::cfg_t      cfg,
  input  wire logic                room,
  output logic                     res_valid,
  output wptd_pkg::result_word_t   res
);

  localparam int WORKERS = wptd_pkg::WORKERS;
  localparam int QD      = wptd_pkg::QUEUE_DEPTH;

  logic [wptd_pkg::LINK_W-1:0]    idle_next [WORKERS];
  logic [wptd_pkg::LINK_W-1:0]    idle_prev [WORKERS];
  logic [wptd_pkg::LINK_W-1:0]    idle_top;
  logic [wptd_pkg::LINK_W-1:0]    idle_bottom;
  logic [wptd_pkg::WID_W-1:0]     unused_stack [WORKERS];
  logic [wptd_pkg::CNT_W-1:0]     unused_count;
  logic [wptd_pkg::TIME_W-1:0]    idle_since [WORKERS];
  logic [wptd_pkg::TASK_BITS-1:0] task_ring [QD];
  logic [wptd_pkg::QIDX_W-1:0]    read_index;
  logic [wptd_pkg::QCNT_W-1:0]    queue_fill;
  logic [wptd_pkg::CNT_W-1:0]     workers_active;
  logic [WORKERS-1:0]             busy;

  wptd_pkg::back_state_t state, state_next;
  wptd_pkg::item_t it;

  logic start, is_sub, is_fin, is_tick;
  logic sub_idle, sub_new, sub_queue;
  logic fin_ok, fin_ring, fin_exit;
  logic [wptd_pkg::WID_W-1:0]  top_w, bot_w, new_w, fin_w;
  logic [wptd_pkg::CNT_W-1:0]  wa_post;
  logic [wptd_pkg::LINK_W-1:0] bottom_post;
  logic [wptd_pkg::TIME_W-1:0] age;
  logic retire_go;
  logic [wptd_pkg::LINK_W-1:0] top_after, prev_of_bot;

  assign it      = front.item;
  assign start   = (state == wptd_pkg::ST_RUN) && front.valid && room;
  assign is_sub  = (it.op == wptd_pkg::OP_SUBMIT);
  assign is_fin  = (it.op == wptd_pkg::OP_FINISH);
  assign is_tick = (it.op == wptd_pkg::OP_TICK);

  assign top_w = idle_top[wptd_pkg::WID_W-1:0];
  assign bot_w = idle_bottom[wptd_pkg::WID_W-1:0];
  assign new_w = unused_stack[wptd_pkg::WID_W'(unused_count - 4'd1)];
  assign fin_w = it.worker_id;

  assign sub_idle  = (idle_top != wptd_pkg::NIL);
  assign sub_new   = !sub_idle && (unused_count != '0);
  assign sub_queue = !sub_idle && !sub_new && (queue_fill < wptd_pkg::QCNT_W'(QD));

  assign fin_ok   = busy[fin_w];
  assign fin_ring = (queue_fill != '0);
  assign fin_exit = (cfg.mode == wptd_pkg::MODE_EXIT);

  // Retirement is judged on the state as the submit leaves it.
  assign wa_post     = workers_active + {3'd0, is_sub && sub_new};
  assign bottom_post = (is_sub && sub_idle && (idle_top == idle_bottom)) ?
                       wptd_pkg::NIL : idle_bottom;
  assign age = it.now - idle_since[bottom_post[wptd_pkg::WID_W-1:0]];
  assign retire_go = (is_sub || is_tick) && cfg.mode[1] && (wa_post > 4'd2) &&
                     (bottom_post != wptd_pkg::NIL) && (age > cfg.timeout);

  assign top_after   = idle_next[top_w];
  assign prev_of_bot = idle_prev[bot_w];

  always_comb begin
    state_next = state;
    case (state)
      wptd_pkg::ST_RUN:    if (start && retire_go) state_next = wptd_pkg::ST_RETIRE;
      wptd_pkg::ST_RETIRE: state_next = wptd_pkg::ST_RUN;
      default:             state_next = wptd_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    take      = 1'b0;
    res_valid = 1'b0;
    res.kind         = wptd_pkg::KIND_REJECTED;
    res.worker_out   = '0;
    res.task_out     = '0;
    res.active_count = workers_active;
    res.queued_count = queue_fill;
    res.last         = 1'b1;
    case (state)
      wptd_pkg::ST_RUN: begin
        take = start;
        if (is_sub) begin
          res_valid = start;
          res.last  = !retire_go;
          if (sub_idle) begin
            res.kind       = wptd_pkg::KIND_TO_IDLE;
            res.worker_out = top_w;
            res.task_out   = it.task_id;
          end else if (sub_new) begin
            res.kind         = wptd_pkg::KIND_TO_NEW;
            res.worker_out   = new_w;
            res.task_out     = it.task_id;
            res.active_count = workers_active + 4'd1;
          end else if (sub_queue) begin
            res.kind         = wptd_pkg::KIND_QUEUED;
            res.queued_count = queue_fill + 5'd1;
          end
        end else if (is_fin) begin
          res_valid      = start && fin_ok;
          res.worker_out = fin_w;
          if (fin_ring) begin
            res.kind         = wptd_pkg::KIND_FROM_Q;
            res.task_out     = task_ring[read_index];
            res.queued_count = queue_fill - 5'd1;
          end else if (fin_exit) begin
            res.kind         = wptd_pkg::KIND_RELEASED;
            res.active_count = workers_active - 4'd1;
          end else begin
            res.kind = wptd_pkg::KIND_PARKED;
          end
        end
      end
      wptd_pkg::ST_RETIRE: begin
        res_valid        = 1'b1;
        res.kind         = wptd_pkg::KIND_RETIRED;
        res.worker_out   = bot_w;
        res.active_count = workers_active - 4'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= wptd_pkg::ST_RUN;
      idle_top       <= wptd_pkg::NIL;
      idle_bottom    <= wptd_pkg::NIL;
      unused_count   <= wptd_pkg::CNT_W'(WORKERS);
      read_index     <= '0;
      queue_fill     <= '0;
      workers_active <= '0;
      busy           <= '0;
      for (int i = 0; i < WORKERS; i++) begin
        idle_next[i]    <= wptd_pkg::NIL;
        idle_prev[i]    <= wptd_pkg::NIL;
        unused_stack[i] <= wptd_pkg::WID_W'(WORKERS - 1 - i);
      end
    end else begin
      state <= state_next;
      if (state == wptd_pkg::ST_RETIRE) begin
        busy[bot_w]    <= 1'b0;
        workers_active <= workers_active - 4'd1;
        if (unused_count < wptd_pkg::CNT_W'(WORKERS)) begin
          unused_stack[unused_count[wptd_pkg::WID_W-1:0]] <= bot_w;
          unused_count <= unused_count + 4'd1;
        end
        idle_bottom <= prev_of_bot;
        if (prev_of_bot != wptd_pkg::NIL)
          idle_next[prev_of_bot[wptd_pkg::WID_W-1:0]] <= wptd_pkg::NIL;
        else
          idle_top <= wptd_pkg::NIL;
      end else if (start && is_sub) begin
        if (sub_idle) begin
          busy[top_w] <= 1'b1;
          idle_top    <= top_after;
          if (top_after != wptd_pkg::NIL)
            idle_prev[top_after[wptd_pkg::WID_W-1:0]] <= wptd_pkg::NIL;
          else
            idle_bottom <= wptd_pkg::NIL;
        end else if (sub_new) begin
          busy[new_w]    <= 1'b1;
          unused_count   <= unused_count - 4'd1;
          workers_active <= workers_active + 4'd1;
        end else if (sub_queue) begin
          queue_fill <= queue_fill + 5'd1;
        end
      end else if (start && is_fin && fin_ok) begin
        if (fin_ring) begin
          read_index <= read_index + 4'd1;
          queue_fill <= queue_fill - 5'd1;
        end else if (fin_exit) begin
          busy[fin_w]    <= 1'b0;
          workers_active <= workers_active - 4'd1;
          if (unused_count < wptd_pkg::CNT_W'(WORKERS)) begin
            unused_stack[unused_count[wptd_pkg::WID_W-1:0]] <= fin_w;
            unused_count <= unused_count + 4'd1;
          end
        end else begin
          busy[fin_w]      <= 1'b0;
          idle_prev[fin_w] <= wptd_pkg::NIL;
          idle_next[fin_w] <= idle_top;
          if (idle_top != wptd_pkg::NIL)
            idle_prev[top_w] <= {1'b0, fin_w};
          else
            idle_bottom <= {1'b0, fin_w};
          idle_top <= {1'b0, fin_w};
        end
      end
    end
  end

  // Time stamps and queued tasks are only read after being written.
  always_ff @(posedge clk) begin
    if (state == wptd_pkg::ST_RUN && start && is_sub && sub_queue)
      task_ring[wptd_pkg::QIDX_W'(read_index + queue_fill[wptd_pkg::QIDX_W-1:0])]
        <= it.task_id;
    if (state == wptd_pkg::ST_RUN && start && is_fin && fin_ok && !fin_ring && !fin_exit)
      idle_since[fin_w] <= it.now;
  end

endmodule
`default_nettype wire

FILE: sv/wptd_out_q.sv
`default_nettype none
module wptd_out_q (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   wr,
  input  wire wptd_pkg::result_word_t wr_data,
  output logic                        room,
  input  wire logic                   pop,
  output logic                        empty,
  output wptd_pkg::result_word_t      result
);

  // Four entries; room means space for the two words one item may produce.
  wptd_pkg::result_word_t q_mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_pop;

  assign empty  = (count == 3'd0);
  assign room   = (count <= 3'd2);
  assign do_pop = pop && !empty;
  assign result = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'd0, wr} - {2'd0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_mem[wr_ptr] <= wr_data;
  end

endmodule
`default_nettype wire

FILE: sv/worker_pool_task_dispatcher_unit.sv
// Worker pool task dispatcher.
// Input side is a queue: drive task_in and raise push; the word is taken at a
// rising edge where push is high and full is low. Commands are submit, worker
// finished and time tick; an unknown command is taken and dropped.
// Output side is a queue too: while empty is low the oldest result word is on
// result, and it is taken at an edge where pop is high. One input word gives
// zero, one or two result words; last marks the final one of each input.
// A two-word front queue holds classified words, the back engine works on one
// at a time, and retiring an idle worker takes an extra ST_RETIRE state after
// the word. An input word is registered in the front queue and its result in
// the result queue before the result shows on result. The engine waits while the
// four-word result queue has fewer than two free places, so a stalled receiver
// fills the result queue, then the front queue, and full then rises.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// Synchronous reset empties both queues, marks all workers unused, clears the
// task ring count and restores idle_mode 2 and idle_timeout 1000.
`default_nettype none
`include "worker_pool_task_dispatcher_unit_assert.svh"
module worker_pool_task_dispatcher_unit (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire wptd_pkg::task_word_t   task_in,
  output logic                        full,
  input  wire logic                   pop,
  output logic                        empty,
  output wptd_pkg::result_word_t      result,
  input  wire logic                   cfg_write,
  input  wire logic                   cfg_index,
  input  wire logic [31:0]            cfg_data
);

  wptd_pkg::cfg_t         cfg;
  wptd_pkg::front_if_t    front;
  wptd_pkg::result_word_t res;
  logic take;
  logic room;
  logic res_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode    <= 2'd2;
      cfg.timeout <= 32'd1000;
    end else if (cfg_write) begin
      case (cfg_index)
        wptd_pkg::REG_IDLE_MODE:    cfg.mode    <= cfg_data[wptd_pkg::MODE_W-1:0];
        wptd_pkg::REG_IDLE_TIMEOUT: cfg.timeout <= cfg_data;
        default: ;
      endcase
    end
  end

  wptd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .task_in (task_in),
    .full    (full),
    .take    (take),
    .front   (front)
  );

  wptd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .front     (front),
    .take      (take),
    .cfg       (cfg),
    .room      (room),
    .res_valid (res_valid),
    .res       (res)
  );

  wptd_out_q u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (res_valid),
    .wr_data (res),
    .room    (room),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // A queued or rejected word names no worker and carries no task.
  `WPTD_ASSERT_NOW(a_queued_clean, clk, rst, !empty && (result.kind == wptd_pkg::KIND_QUEUED || result.kind == wptd_pkg::KIND_REJECTED), result.worker_out == '0 && result.task_out == '0)
  // A reject only happens with the task ring full.
  `WPTD_ASSERT_NOW(a_reject_full, clk, rst, !empty && result.kind == wptd_pkg::KIND_REJECTED, result.queued_count == 5'd16)
  // A waiting result stays while it is not taken.
  `WPTD_ASSERT_NEXT(a_result_kept, clk, rst, !empty && !pop, !empty)

endmodule
`default_nettype wire
